### hdl/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Types and constants shared by the glyph pixel rasterizer modules.
// ----------------------------------------------------------------------------
package gpr_pkg;

  localparam int POS_W    = 12;
  localparam int WIDTH_W  = 13;
  localparam int OFFS_W   = 24;
  localparam int COLOUR_W = 32;
  localparam int BYTE_W   = 8;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [WIDTH_W-1:0] ROW_PITCH_RESET = 13'd1920;
  localparam logic [6:0]         CODE_MASK       = 7'h7F;
  localparam logic [6:0]         CODE_SPACE      = 7'h20;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_PITCH = 1'b0;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [7:0]          char_code;
    logic [6:0]          glyph_index;
    logic [2:0]          glyph_column;
    logic [BYTE_W-1:0]   font_byte;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [COLOUR_W-1:0] colour;
  } req_t;

  typedef struct packed {
    logic [OFFS_W-1:0]   pixel_offset;
    logic [COLOUR_W-1:0] pixel_value;
    logic                write_enable;
    logic                last;
  } pix_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_BASE,
    ST_RUN
  } seq_state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MUL,
    OP_BASE,
    OP_ROW,
    OP_COL
  } offs_op_t;

  typedef struct packed {
    offs_op_t op;
  } offs_ctrl_t;

endpackage

### hdl/gpr_glyph_ram.sv
// ----------------------------------------------------------------------------
// gpr_glyph_ram
// Glyph column byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gpr_glyph_ram #(
  parameter int DEPTH  = 576,
  parameter int ADDR_W = 10
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [gpr_pkg::BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [gpr_pkg::BYTE_W-1:0] rd_data
);
  import gpr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/gpr_offset_unit.sv
// ----------------------------------------------------------------------------
// gpr_offset_unit
// Framebuffer offset generator built around one shared 24-bit adder.
// ----------------------------------------------------------------------------
module gpr_offset_unit (
  input  logic                        clk,
  input  gpr_pkg::offs_ctrl_t         ctrl,
  input  logic [gpr_pkg::POS_W-1:0]   pos_x,
  input  logic [gpr_pkg::POS_W-1:0]   pos_y,
  input  logic [gpr_pkg::WIDTH_W-1:0] row_pitch,
  output logic [gpr_pkg::OFFS_W-1:0]  offset
);
  import gpr_pkg::*;

  logic [OFFS_W-1:0] prod;
  logic [OFFS_W-1:0] col_base;
  logic [OFFS_W-1:0] add_a;
  logic [OFFS_W-1:0] add_b;
  logic [OFFS_W-1:0] add_sum;

  // operand select: base = y*w + x, row step adds width, column step
  // restarts from the column base plus one
  always_comb begin
    case (ctrl.op)
      OP_BASE: begin
        add_a = prod;
        add_b = OFFS_W'(pos_x);
      end
      OP_ROW: begin
        add_a = offset;
        add_b = OFFS_W'(row_pitch);
      end
      OP_COL: begin
        add_a = col_base;
        add_b = OFFS_W'(1);
      end
      default: begin
        add_a = offset;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_MUL: begin
        prod <= OFFS_W'(pos_y * row_pitch);
      end
      OP_BASE, OP_COL: begin
        offset   <= add_sum;
        col_base <= add_sum;
      end
      OP_ROW: begin
        offset <= add_sum;
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/gpr_sequencer.sv
// ----------------------------------------------------------------------------
// gpr_sequencer
// Command decode, glyph store addressing and the row/column pixel walk.
// ----------------------------------------------------------------------------
module gpr_sequencer #(
  parameter int GLYPH_COLUMNS = 6,
  parameter int GLYPH_ROWS    = 8,
  parameter int GLYPH_COUNT   = 96,
  parameter int ADDR_W        = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  gpr_pkg::req_t                req,
  output logic                         busy,
  output logic                         wr_en,
  output logic [ADDR_W-1:0]            wr_addr,
  output logic [gpr_pkg::BYTE_W-1:0]   wr_data,
  output logic [ADDR_W-1:0]            rd_addr_next,
  input  logic [gpr_pkg::BYTE_W-1:0]   rd_data,
  output gpr_pkg::offs_ctrl_t          ctrl,
  output logic [gpr_pkg::POS_W-1:0]    pos_x,
  output logic [gpr_pkg::POS_W-1:0]    pos_y,
  input  logic [gpr_pkg::OFFS_W-1:0]   offset,
  output gpr_pkg::pix_t                pix,
  output logic                         pix_valid
);
  import gpr_pkg::*;

  localparam int ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int COL_W = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;

  seq_state_t          state;
  seq_state_t          state_next;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic [ADDR_W-1:0]   rd_addr;
  logic [COLOUR_W-1:0] colour;
  logic                blank;

  logic                accept;
  logic                draw;
  logic                last_row;
  logic                last_col;
  logic [6:0]          code7;
  logic [7:0]          glyph;
  logic                glyph_blank;
  logic [BYTE_W-1:0]   col_bits;
  logic                pix_bit;

  assign accept   = start && (state == ST_IDLE);
  assign draw     = accept && (req.cmd == CMD_DRAW);
  assign busy     = (state != ST_IDLE);
  assign last_row = (row == ROW_W'(GLYPH_ROWS - 1));
  assign last_col = (col == COL_W'(GLYPH_COLUMNS - 1));

  // character code to glyph number
  assign code7       = req.char_code[6:0] & CODE_MASK;
  assign glyph       = (code7 < CODE_SPACE) ? 8'd0 : 8'(code7 - CODE_SPACE);
  assign glyph_blank = (32'(glyph) >= GLYPH_COUNT);

  // load path
  assign wr_en   = accept && (req.cmd == CMD_LOAD)
                   && (32'(req.glyph_index) < GLYPH_COUNT)
                   && (32'(req.glyph_column) < GLYPH_COLUMNS);
  assign wr_addr = ADDR_W'(32'(req.glyph_index) * GLYPH_COLUMNS + 32'(req.glyph_column));
  assign wr_data = req.font_byte;

  assign col_bits = blank ? '0 : rd_data;
  assign pix_bit  = col_bits[3'(row)];

  always_comb begin
    state_next   = state;
    rd_addr_next = rd_addr;
    ctrl.op      = OP_HOLD;
    case (state)
      ST_IDLE: begin
        if (draw) begin
          state_next   = ST_MUL;
          rd_addr_next = glyph_blank ? '0 : ADDR_W'(32'(glyph) * GLYPH_COLUMNS);
        end
      end
      ST_MUL: begin
        ctrl.op    = OP_MUL;
        state_next = ST_BASE;
      end
      ST_BASE: begin
        ctrl.op    = OP_BASE;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last_row) begin
          ctrl.op = OP_COL;
          if (last_col) begin
            state_next = ST_IDLE;
          end else if (!blank) begin
            rd_addr_next = rd_addr + ADDR_W'(1);
          end
        end else begin
          ctrl.op = OP_ROW;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= '0;
      col       <= '0;
      pix_valid <= 1'b0;
      rd_addr   <= '0;
    end else begin
      state     <= state_next;
      rd_addr   <= rd_addr_next;
      pix_valid <= (state == ST_RUN);
      if (state == ST_RUN) begin
        if (last_row) begin
          row <= '0;
          col <= last_col ? '0 : col + COL_W'(1);
        end else begin
          row <= row + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      pos_x  <= req.pos_x;
      pos_y  <= req.pos_y;
      colour <= req.colour;
      blank  <= glyph_blank;
    end
    pix.pixel_offset <= offset;
    pix.pixel_value  <= colour;
    pix.write_enable <= pix_bit;
    pix.last         <= last_row && last_col;
  end

  a_last_ends_char: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix.last |=> !pix_valid)
    else $error("pixel strobe continued after last pixel");

  a_strobe_from_run: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> $past(state) == ST_RUN)
    else $error("pixel strobe outside pixel walk");

  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> (row == '0) && (col == '0))
    else $error("walk counters not cleared at idle");

  a_draw_starts: assert property (@(posedge clk) disable iff (rst)
    draw |=> state == ST_MUL)
    else $error("draw request did not start the sequence");

endmodule

### hdl/glyph_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// glyph_pixel_rasterizer
// 6x8 bitmap font character generator: one pixel write per cycle while drawing.
// ----------------------------------------------------------------------------
// Load request: busy stays low, so the next request can follow next cycle.
// Draw request: busy through a multiply step and a base-add step, then one
// pixel per cycle through the shared offset adder. The first pixel strobe is
// registered from ST_RUN; a new draw is accepted only back at idle.
// Pixels cannot be stalled. rst clears the sequencer state, counters, read
// address and pix_valid, and row_pitch (1920) only.
module glyph_pixel_rasterizer #(
  parameter int GLYPH_COLUMNS = 6,
  parameter int GLYPH_ROWS    = 8,
  parameter int GLYPH_COUNT   = 96
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  gpr_pkg::req_t               req,
  output gpr_pkg::pix_t               pix,
  output logic                        pix_valid,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gpr_pkg::APB_AW-1:0]  paddr,
  input  logic [gpr_pkg::APB_DW-1:0]  pwdata,
  output logic [gpr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import gpr_pkg::*;

  localparam int DEPTH  = GLYPH_COUNT * GLYPH_COLUMNS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH_W-1:0] row_pitch;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [BYTE_W-1:0]  wr_data;
  logic [ADDR_W-1:0]  rd_addr_next;
  logic [BYTE_W-1:0]  rd_data;
  offs_ctrl_t         ctrl;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [OFFS_W-1:0]  offset;

  // register file
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROW_PITCH) ? APB_DW'(row_pitch) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch <= ROW_PITCH_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == REG_ROW_PITCH)) begin
      row_pitch <= pwdata[WIDTH_W-1:0];
    end
  end

  gpr_sequencer #(
    .GLYPH_COLUMNS (GLYPH_COLUMNS),
    .GLYPH_ROWS    (GLYPH_ROWS),
    .GLYPH_COUNT   (GLYPH_COUNT),
    .ADDR_W        (ADDR_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr_next (rd_addr_next),
    .rd_data      (rd_data),
    .ctrl         (ctrl),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .offset       (offset),
    .pix          (pix),
    .pix_valid    (pix_valid)
  );

  gpr_glyph_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr_next),
    .rd_data (rd_data)
  );

  gpr_offset_unit u_offs (
    .clk       (clk),
    .ctrl      (ctrl),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .row_pitch (row_pitch),
    .offset    (offset)
  );

endmodule

### verif/glyph_pixel_checker.sv
// ----------------------------------------------------------------------------
// glyph_pixel_checker
// Watches the request, pixel and register ports of the glyph pixel
// rasterizer. Keeps its own glyph store and screen width, renders every
// accepted draw into a queue of due pixels and compares each pixel strobe,
// field by field, with the oldest due pixel. Register reads are checked too.
// ----------------------------------------------------------------------------
module glyph_pixel_checker #(
  parameter int GLYPH_COLUMNS = 6,
  parameter int GLYPH_ROWS    = 8,
  parameter int GLYPH_COUNT   = 96
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  gpr_pkg::req_t               req,
  input  gpr_pkg::pix_t               pix,
  input  logic                        pix_valid,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gpr_pkg::APB_AW-1:0]  paddr,
  input  logic [gpr_pkg::APB_DW-1:0]  pwdata,
  input  logic [gpr_pkg::APB_DW-1:0]  prdata,
  input  logic                        pready,
  output int                          pixels_pending,
  output int                          pixels_checked,
  output int                          fail_count
);

  import gpr_pkg::*;

  localparam logic [APB_AW-1:0] ROW_PITCH_ADDR = {REG_ROW_PITCH, 2'b00};

  logic [BYTE_W-1:0]  font_mem [GLYPH_COUNT*GLYPH_COLUMNS];
  logic [WIDTH_W-1:0] row_pitch = ROW_PITCH_RESET;
  pix_t               pixels_due [$];
  int                 checked = 0;
  int                 fails = 0;

  function automatic logic [6:0] glyph_of(input logic [7:0] code);
    logic [6:0] c;
    c = code[6:0] & CODE_MASK;
    return (c < CODE_SPACE) ? 7'd0 : c - CODE_SPACE;
  endfunction

  // column-major: all rows of column 0 first
  task automatic render_glyph(input req_t r);
    logic [6:0]        glyph;
    logic [BYTE_W-1:0] bits;
    logic [31:0]       offs;
    pix_t              p;
    glyph = glyph_of(r.char_code);
    for (int col = 0; col < GLYPH_COLUMNS; col++) begin
      bits = (glyph < GLYPH_COUNT) ? font_mem[glyph*GLYPH_COLUMNS + col] : '0;
      for (int row = 0; row < GLYPH_ROWS; row++) begin
        offs = (32'(r.pos_y) + row) * row_pitch + 32'(r.pos_x) + col;
        p.pixel_offset = offs[OFFS_W-1:0];
        p.pixel_value  = r.colour;
        p.write_enable = bits[row];
        p.last         = (col == GLYPH_COLUMNS-1) && (row == GLYPH_ROWS-1);
        pixels_due.push_back(p);
      end
    end
  endtask

  task automatic note_failure(input string msg);
    fails++;
    if (fails <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    pix_t want;
    if (rst) begin
      row_pitch = ROW_PITCH_RESET;
      pixels_due.delete();
    end else begin
      if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1 &&
          paddr == ROW_PITCH_ADDR) begin
        if (pwrite === 1'b1) begin
          row_pitch = pwdata[WIDTH_W-1:0];
        end else if (prdata !== APB_DW'(row_pitch)) begin
          note_failure($sformatf("row pitch read: expected %0d, got %h",
                                 row_pitch, prdata));
        end
      end

      if (pix_valid === 1'b1) begin
        if (pixels_due.size() == 0) begin
          note_failure($sformatf("pixel with none due: off %h val %h we %b last %b",
                                 pix.pixel_offset, pix.pixel_value,
                                 pix.write_enable, pix.last));
        end else begin
          want = pixels_due.pop_front();
          checked++;
          if (pix.pixel_offset !== want.pixel_offset ||
              pix.pixel_value  !== want.pixel_value  ||
              pix.write_enable !== want.write_enable ||
              pix.last         !== want.last) begin
            note_failure($sformatf(
              "pixel %0d: exp off %h val %h we %b last %b, got off %h val %h we %b last %b",
              checked, want.pixel_offset, want.pixel_value, want.write_enable, want.last,
              pix.pixel_offset, pix.pixel_value, pix.write_enable, pix.last));
          end
        end
      end

      if (start === 1'b1 && busy === 1'b0) begin
        if (req.cmd == CMD_LOAD) begin
          // out-of-range loads leave the store alone
          if (req.glyph_index < GLYPH_COUNT && req.glyph_column < GLYPH_COLUMNS)
            font_mem[req.glyph_index*GLYPH_COLUMNS + req.glyph_column] = req.font_byte;
        end else begin
          render_glyph(req);
        end
      end
    end
    pixels_pending <= pixels_due.size();
    pixels_checked <= checked;
    fail_count     <= fails;
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the glyph pixel rasterizer. Loads glyphs, draws
// characters across control, space, high-bit and edge codes at the corners of
// the position range, and sweeps screen widths (reset, 1, 4096, 8191, 0 and
// random) via the register port; the sender idles at random in most phases.
// ----------------------------------------------------------------------------
module tb_top;

  import gpr_pkg::*;

  localparam int GLYPH_COLUMNS   = 6;
  localparam int GLYPH_ROWS      = 8;
  localparam int GLYPH_COUNT     = 96;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 34;
  localparam logic [APB_AW-1:0] ROW_PITCH_ADDR = {REG_ROW_PITCH, 2'b00};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  req_t              req = '0;
  pix_t              pix;
  logic              pix_valid;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int pixels_pending;
  int pixels_checked;
  int fail_count;
  int cycle_count = 0;
  int idle_pct = 19;
  int loads_sent = 0;
  int ignored_sent = 0;
  int draws_sent = 0;

  logic [GLYPH_COLUMNS-1:0] cols_loaded [GLYPH_COUNT];

  always #10 clk = ~clk;

  glyph_pixel_rasterizer #(
    .GLYPH_COLUMNS (GLYPH_COLUMNS),
    .GLYPH_ROWS    (GLYPH_ROWS),
    .GLYPH_COUNT   (GLYPH_COUNT)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .pix       (pix),
    .pix_valid (pix_valid),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  glyph_pixel_checker #(
    .GLYPH_COLUMNS (GLYPH_COLUMNS),
    .GLYPH_ROWS    (GLYPH_ROWS),
    .GLYPH_COUNT   (GLYPH_COUNT)
  ) u_pixel_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req            (req),
    .pix            (pix),
    .pix_valid      (pix_valid),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .pixels_pending (pixels_pending),
    .pixels_checked (pixels_checked),
    .fail_count     (fail_count)
  );

  // unused fields of a request carry random bits
  function automatic req_t noise_req();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  // start is re-decided every cycle so idle cycles land anywhere in a draw
  task automatic issue(input req_t r);
    logic go;
    do begin
      go = ($urandom_range(99) >= idle_pct);
      start <= go;
      req   <= r;
      @(posedge clk);
    end while (!(go && busy === 1'b0));
  endtask

  task automatic load_column(input int glyph, input int col, input logic [7:0] bits);
    req_t r;
    r = noise_req();
    r.cmd          = CMD_LOAD;
    r.glyph_index  = 7'(glyph);
    r.glyph_column = 3'(col);
    r.font_byte    = bits;
    issue(r);
    if (glyph < GLYPH_COUNT && col < GLYPH_COLUMNS) begin
      cols_loaded[glyph][col] = 1'b1;
      loads_sent++;
    end else begin
      ignored_sent++;
    end
  endtask

  task automatic draw_char(input logic [7:0] code, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic [COLOUR_W-1:0] colour);
    req_t r;
    r = noise_req();
    r.cmd       = CMD_DRAW;
    r.char_code = code;
    r.pos_x     = x;
    r.pos_y     = y;
    r.colour    = colour;
    issue(r);
    draws_sent++;
  endtask

  // hold off until every due pixel is out and the sequencer is back to idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_access(input logic is_write, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ROW_PITCH_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int               glyph;
    int               rot;
    int               done;
    int               pick;
    int               ready_q [$];
    logic [6:0]       code7;
    logic [APB_DW-1:0] data;
    foreach (cols_loaded[g]) cols_loaded[g] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_access(1'b0, '0);

    // directed: glyph 0 (control codes and space) and glyph 95 (code 0x7F)
    load_column(0, 0, 8'h00);
    load_column(0, 1, 8'hFF);
    load_column(0, 2, 8'hA5);
    load_column(0, 3, 8'h5A);
    load_column(0, 4, 8'h81);
    load_column(0, 5, 8'h7E);
    for (int k = 0; k < GLYPH_COLUMNS; k++) load_column(GLYPH_COUNT-1, k, 8'($urandom));
    load_column(127, 0, 8'hFF);
    load_column(GLYPH_COUNT, GLYPH_COLUMNS-1, 8'hFF);
    load_column(10, GLYPH_COLUMNS, 8'hFF);
    load_column(0, 7, 8'h00);
    draw_char(8'h00, '0, '0, '0);
    draw_char(8'h1F, '1, '1, '1);
    draw_char(8'h20, '0, '1, $urandom);
    draw_char(8'h7F, '1, '0, $urandom);
    draw_char(8'hFF, POS_W'($urandom), POS_W'($urandom), $urandom);
    draw_char(8'hA0, POS_W'($urandom), POS_W'($urandom), $urandom);
    draw_char(8'h9F, POS_W'($urandom), POS_W'($urandom), $urandom);

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_pct = (phase < 2) ? 19 : (phase < 4) ? 54 : 0;
      drain();
      data = $urandom;
      case (phase)
        0:       data[WIDTH_W-1:0] = 13'd1;
        1:       data[WIDTH_W-1:0] = 13'($urandom_range(2, 4095));
        2:       data[WIDTH_W-1:0] = 13'd8191;
        3:       data[WIDTH_W-1:0] = 13'd0;
        4:       data[WIDTH_W-1:0] = 13'd4096;
        default: data[WIDTH_W-1:0] = 13'($urandom);
      endcase
      reg_access(1'b1, data);
      reg_access(1'b0, '0);

      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          glyph = $urandom_range(GLYPH_COUNT-1);
          rot   = $urandom_range(GLYPH_COLUMNS-1);
          for (int k = 0; k < GLYPH_COLUMNS; k++)
            load_column(glyph, (k + rot) % GLYPH_COLUMNS, 8'($urandom));
          done += GLYPH_COLUMNS;
        end else if (pick < 25) begin
          load_column($urandom_range(GLYPH_COUNT-1), $urandom_range(GLYPH_COLUMNS-1),
                      8'($urandom));
          done++;
        end else if (pick < 30) begin
          if ($urandom_range(1))
            load_column($urandom_range(GLYPH_COUNT, 127), $urandom_range(7),
                        8'($urandom));
          else
            load_column($urandom_range(127), $urandom_range(GLYPH_COLUMNS, 7),
                        8'($urandom));
          done++;
        end else begin
          // only fully loaded glyphs are drawn
          ready_q.delete();
          for (int g = 0; g < GLYPH_COUNT; g++)
            if (&cols_loaded[g]) ready_q.push_back(g);
          glyph = ready_q[$urandom_range(ready_q.size()-1)];
          code7 = (glyph == 0) ? 7'($urandom_range(CODE_SPACE)) : 7'(glyph + CODE_SPACE);
          draw_char({1'($urandom_range(1)), code7}, POS_W'($urandom), POS_W'($urandom),
                    $urandom);
          done++;
        end
      end
    end

    drain();
    $display("Run: %0d loads, %0d out-of-range loads, %0d draws, %0d pixels compared.",
             loads_sent, ignored_sent, draws_sent, pixels_checked);
    $display("Screen widths 1920, 1, 8191, 0, 4096 and random; sender idle 19, 54, 0 pct.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d pixels still due", cycle_count, pixels_pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
